>>> hw/rtl/ift_pkg.sv
// Shared types, register indexes and field layout of the infrared frame transmitter.
package ift_pkg;

  localparam int MAX_BYTES = 16;
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int PTR_W     = $clog2(MAX_BYTES + 1);
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // Stream payload widths and positions.
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_BUSY_BIT = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PRESCALE     = 3'd0,
    REG_LEAD_MARK    = 3'd1,
    REG_LEAD_SPACE   = 3'd2,
    REG_ZERO_MARK    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_ONE_MARK     = 3'd5,
    REG_ONE_SPACE    = 3'd6,
    REG_CARRIER_DUTY = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_STOP_MARK  = 3'd5
  } phase_t;

  localparam logic [7:0] PRESCALE_RST     = 8'h07;
  localparam logic [7:0] LEAD_MARK_RST    = 8'h29;
  localparam logic [7:0] LEAD_SPACE_RST   = 8'h14;
  localparam logic [7:0] ZERO_MARK_RST    = 8'h01;
  localparam logic [7:0] ZERO_SPACE_RST   = 8'h01;
  localparam logic [7:0] ONE_MARK_RST     = 8'h01;
  localparam logic [7:0] ONE_SPACE_RST    = 8'h07;
  localparam logic [7:0] CARRIER_DUTY_RST = 8'h46;

endpackage

>>> hw/rtl/ir_frame_transmitter_unit.sv
// Top level of the infrared frame transmitter: frame store, phase sequencer and result register.
//
//  Channel   Direction  Transfer when                  Contents
//  s_axis    in         s_axis_tvalid & s_axis_tready  op, store position, byte, frame length
//  m_axis    out        m_axis_tvalid & m_axis_tready  compare value, busy, end of frame
//  cfg       in         cfg_we                         register index and 8-bit value
//
// Each item updates the sequencer state at the transfer edge and its result appears in the
// output register on the next cycle, so one item per cycle is sustained unless the output stalls.
// The input is ready whenever the output register is empty or being drained in the same cycle.
// A stalled output holds its result and blocks further input until taken.
// Reset (synchronous) returns the sequencer to idle and the registers to their defaults.
module ir_frame_transmitter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ift_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                        cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // from bit 0: byte_index[3:0], byte_value[11:4], frame_len[16:12], zero fill
  input  logic [ift_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // from bit 0: op[1:0]
  input  logic [ift_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // from bit 0: pwm_compare[7:0], busy_res[8], zero fill
  output logic [ift_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // frame_done
  output logic                              m_axis_tlast
);
  import ift_pkg::*;

  // Configuration registers.
  logic [7:0] prescale_limit;
  logic [7:0] leader_mark_limit;
  logic [7:0] leader_space_limit;
  logic [7:0] zero_mark_limit;
  logic [7:0] zero_space_limit;
  logic [7:0] one_mark_limit;
  logic [7:0] one_space_limit;
  logic [7:0] carrier_duty;

  // Sequencer state.
  phase_t           phase, phase_next;
  logic [7:0]       prescale_count, prescale_count_next;
  logic [7:0]       duration_count, duration_count_next;
  logic [PTR_W-1:0] byte_pointer, byte_pointer_next;
  logic [2:0]       bit_pointer, bit_pointer_next;
  logic [7:0]       mark_limit, mark_limit_next;
  logic [7:0]       space_limit, space_limit_next;
  logic [PTR_W-1:0] frame_length, frame_length_next;
  logic [7:0]       frame_store [MAX_BYTES];
  logic [7:0]       store_byte;

  // Result register.
  logic       out_valid;
  logic [7:0] pwm_compare, pwm_compare_next;
  logic       busy_res, busy_res_next;
  logic       frame_done, frame_done_next;

  op_t              op;
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       byte_value;
  logic [4:0]       frame_len;
  logic             accept;
  logic             busy;
  logic [7:0]       phase_limit;
  logic             elapsed;
  logic             cur_bit;

  assign op         = op_t'(s_axis_tuser[1:0]);
  assign byte_index = s_axis_tdata[IDX_W-1:0];
  assign byte_value = s_axis_tdata[11:4];
  assign frame_len  = s_axis_tdata[16:12];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign busy          = (phase != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_limit     <= PRESCALE_RST;
      leader_mark_limit  <= LEAD_MARK_RST;
      leader_space_limit <= LEAD_SPACE_RST;
      zero_mark_limit    <= ZERO_MARK_RST;
      zero_space_limit   <= ZERO_SPACE_RST;
      one_mark_limit     <= ONE_MARK_RST;
      one_space_limit    <= ONE_SPACE_RST;
      carrier_duty       <= CARRIER_DUTY_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PRESCALE:     prescale_limit     <= cfg_data;
        REG_LEAD_MARK:    leader_mark_limit  <= cfg_data;
        REG_LEAD_SPACE:   leader_space_limit <= cfg_data;
        REG_ZERO_MARK:    zero_mark_limit    <= cfg_data;
        REG_ZERO_SPACE:   zero_space_limit   <= cfg_data;
        REG_ONE_MARK:     one_mark_limit     <= cfg_data;
        REG_ONE_SPACE:    one_space_limit    <= cfg_data;
        REG_CARRIER_DUTY: carrier_duty       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Limit of the phase in progress; marks after the leader reuse the latched mark length.
  always_comb begin
    case (phase)
      PH_LEAD_MARK:  phase_limit = leader_mark_limit;
      PH_LEAD_SPACE: phase_limit = leader_space_limit;
      PH_BIT_SPACE:  phase_limit = space_limit;
      PH_BIT_MARK,
      PH_STOP_MARK:  phase_limit = mark_limit;
      default:       phase_limit = 8'd0;
    endcase
  end

  assign elapsed = (duration_count >= phase_limit);
  assign cur_bit = (byte_pointer < PTR_W'(MAX_BYTES)) ? store_byte[bit_pointer] : 1'b0;

  // Next state.
  always_comb begin
    phase_next          = phase;
    prescale_count_next = prescale_count;
    duration_count_next = duration_count;
    byte_pointer_next   = byte_pointer;
    bit_pointer_next    = bit_pointer;
    mark_limit_next     = mark_limit;
    space_limit_next    = space_limit;
    frame_length_next   = frame_length;
    frame_done_next     = 1'b0;
    if (accept) begin
      case (op)
        OP_TICK: begin
          if (busy) begin
            if (prescale_count < prescale_limit) begin
              prescale_count_next = prescale_count + 8'd1;
            end else begin
              prescale_count_next = 8'd0;
              duration_count_next = elapsed ? 8'd0 : duration_count + 8'd1;
              if (elapsed) begin
                case (phase)
                  PH_LEAD_MARK: phase_next = PH_LEAD_SPACE;
                  PH_LEAD_SPACE: begin
                    mark_limit_next  = zero_mark_limit;
                    space_limit_next = zero_space_limit;
                    phase_next       = PH_BIT_MARK;
                  end
                  PH_BIT_MARK: begin
                    mark_limit_next  = cur_bit ? one_mark_limit : zero_mark_limit;
                    space_limit_next = cur_bit ? one_space_limit : zero_space_limit;
                    if (bit_pointer != 3'd7) begin
                      bit_pointer_next = bit_pointer + 3'd1;
                    end else begin
                      bit_pointer_next  = 3'd0;
                      byte_pointer_next = byte_pointer + PTR_W'(1);
                    end
                    phase_next = PH_BIT_SPACE;
                  end
                  PH_BIT_SPACE: begin
                    phase_next = (byte_pointer < frame_length) ? PH_BIT_MARK : PH_STOP_MARK;
                  end
                  PH_STOP_MARK: begin
                    phase_next      = PH_IDLE;
                    frame_done_next = 1'b1;
                  end
                  default: phase_next = PH_IDLE;
                endcase
              end
            end
          end
        end
        OP_START: begin
          if (!busy && frame_len != 5'd0) begin
            frame_length_next   = (frame_len > 5'(MAX_BYTES)) ? PTR_W'(MAX_BYTES)
                                                              : PTR_W'(frame_len);
            byte_pointer_next   = '0;
            bit_pointer_next    = 3'd0;
            prescale_count_next = 8'd0;
            duration_count_next = 8'd0;
            phase_next          = PH_LEAD_MARK;
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields follow the phase that this item leaves behind.
  always_comb begin
    case (phase_next)
      PH_LEAD_MARK,
      PH_BIT_MARK,
      PH_STOP_MARK: pwm_compare_next = carrier_duty;
      default:      pwm_compare_next = 8'd0;
    endcase
    busy_res_next = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      prescale_count <= 8'd0;
      duration_count <= 8'd0;
      byte_pointer   <= '0;
      bit_pointer    <= 3'd0;
      mark_limit     <= 8'd0;
      space_limit    <= 8'd0;
      frame_length   <= '0;
    end else begin
      phase          <= phase_next;
      prescale_count <= prescale_count_next;
      duration_count <= duration_count_next;
      byte_pointer   <= byte_pointer_next;
      bit_pointer    <= bit_pointer_next;
      mark_limit     <= mark_limit_next;
      space_limit    <= space_limit_next;
      frame_length   <= frame_length_next;
    end
  end

  // The store only changes while idle, so the byte under the pointer is registered from the next pointer value.
  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD && !busy) begin
      frame_store[byte_index] <= byte_value;
    end
    store_byte <= frame_store[byte_pointer_next[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pwm_compare <= pwm_compare_next;
      busy_res    <= busy_res_next;
      frame_done  <= frame_done_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BUSY_BIT - 1){1'b0}}, busy_res, pwm_compare};
  assign m_axis_tlast  = frame_done;

endmodule

>>> hw/rtl/ift_port_checker.sv
// Port-level checks of the infrared frame transmitter and their binding to the top level.
module ift_port_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [ift_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                              m_axis_tlast
);
  import ift_pkg::*;

  // Every accepted item yields a result on the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // The end of a frame always leaves the transmitter idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[OUT_BUSY_BIT])
    else $error("frame end reported while still busy");

  // No carrier while idle.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[OUT_BUSY_BIT] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("carrier compare non-zero while idle");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind ir_frame_transmitter_unit ift_port_checker u_port_checker (.*);

>>> bench/ir_frame_transmitter_unit_tb.sv
// Self-checking bench for the infrared frame transmitter: stream stimulus, predicted outputs, comparison.
module ir_frame_transmitter_unit_tb;
  import ift_pkg::*;

  localparam int TOTAL_ITEMS = 1150;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [7:0] pwm_compare;
    logic       busy;
    logic       frame_done;
  } tx_output_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_index = '0;
  logic [7:0]             cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // from bit 0: byte_index[3:0], byte_value[11:4], frame_len[16:12], zero fill
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // from bit 0: op[1:0]
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // from bit 0: pwm_compare[7:0], busy_res[8], zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // frame_done
  logic                   m_axis_tlast;

  // Mirror of the transmitter: registers, sequencer and frame store.
  logic [7:0]       reg_shadow [NUM_REGS];
  phase_t           ph = PH_IDLE;
  logic [7:0]       prescale_cnt = '0;
  logic [7:0]       span_cnt = '0;
  logic [7:0]       mark_len = '0;
  logic [7:0]       space_len = '0;
  logic [PTR_W-1:0] byte_ptr = '0;
  logic [PTR_W-1:0] send_len = '0;
  logic [2:0]       bit_ptr = '0;
  logic [7:0]       frame_store [MAX_BYTES];

  tx_output_t expected_outputs[$];
  int error_count = 0;
  int item_count = 0;
  int src_gap_max = 7;
  int sink_stall_max = 7;
  int stall_left = 0;
  int cycle_count = 0;

  ir_frame_transmitter_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit span_elapsed(logic [7:0] limit);
    if (span_cnt < limit) begin
      span_cnt = span_cnt + 8'd1;
      return 1'b0;
    end
    span_cnt = '0;
    return 1'b1;
  endfunction

  function automatic void pick_bit_timing(logic one);
    mark_len  = one ? reg_shadow[REG_ONE_MARK] : reg_shadow[REG_ZERO_MARK];
    space_len = one ? reg_shadow[REG_ONE_SPACE] : reg_shadow[REG_ZERO_SPACE];
  endfunction

  // Advances the sequencer by one slow tick; returns 1 when the stop mark ends.
  function automatic bit slow_tick_step();
    logic [7:0] cur_byte;
    bit         done;
    done = 1'b0;
    case (ph)
      PH_LEAD_MARK: begin
        if (span_elapsed(reg_shadow[REG_LEAD_MARK])) ph = PH_LEAD_SPACE;
      end
      PH_LEAD_SPACE: begin
        if (span_elapsed(reg_shadow[REG_LEAD_SPACE])) begin
          pick_bit_timing(1'b0);
          ph = PH_BIT_MARK;
        end
      end
      PH_BIT_MARK: begin
        if (span_elapsed(mark_len)) begin
          cur_byte = (byte_ptr < MAX_BYTES) ? frame_store[byte_ptr[IDX_W-1:0]] : 8'd0;
          // The bit just sent picks the space now and the mark that follows.
          pick_bit_timing(cur_byte[bit_ptr]);
          if (bit_ptr < 3'd7) begin
            bit_ptr = bit_ptr + 3'd1;
          end else begin
            bit_ptr  = '0;
            byte_ptr = byte_ptr + PTR_W'(1);
          end
          ph = PH_BIT_SPACE;
        end
      end
      PH_BIT_SPACE: begin
        if (span_elapsed(space_len)) ph = (byte_ptr < send_len) ? PH_BIT_MARK : PH_STOP_MARK;
      end
      PH_STOP_MARK: begin
        if (span_elapsed(mark_len)) begin
          ph           = PH_IDLE;
          prescale_cnt = '0;
          span_cnt     = '0;
          done         = 1'b1;
        end
      end
      default: ph = PH_IDLE;
    endcase
    return done;
  endfunction

  // Updates the mirror for one accepted item and queues the output it should give.
  function automatic void predict_frame_output(op_t op, logic [3:0] idx, logic [7:0] val,
                                               logic [4:0] len);
    bit         busy_before;
    bit         done;
    tx_output_t want;
    busy_before = (ph != PH_IDLE);
    done        = 1'b0;
    case (op)
      OP_TICK: if (busy_before) begin
        if (prescale_cnt < reg_shadow[REG_PRESCALE]) begin
          prescale_cnt = prescale_cnt + 8'd1;
        end else begin
          prescale_cnt = '0;
          done = slow_tick_step();
        end
      end
      OP_LOAD: if (!busy_before) begin
        frame_store[idx] = val;
      end
      OP_START: if (!busy_before && len != 0) begin
        send_len     = (len > MAX_BYTES) ? PTR_W'(MAX_BYTES) : len;
        byte_ptr     = '0;
        bit_ptr      = '0;
        prescale_cnt = '0;
        span_cnt     = '0;
        ph           = PH_LEAD_MARK;
      end
      default: ;
    endcase
    want.pwm_compare = (ph inside {PH_LEAD_MARK, PH_BIT_MARK, PH_STOP_MARK}) ?
                       reg_shadow[REG_CARRIER_DUTY] : 8'd0;
    want.busy        = (ph != PH_IDLE);
    want.frame_done  = done;
    expected_outputs.push_back(want);
  endfunction

  // Drives one item and returns at the edge of its transfer. Valid is left high so
  // that a following item with no gap goes out back to back.
  task automatic send_item(op_t op, logic [3:0] idx, logic [7:0] val, logic [4:0] len);
    int gap;
    gap = $urandom_range(src_gap_max, 0);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_TDATA_W - 17){1'b0}}, len, val, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_frame_output(op, idx, val, len);
    item_count++;
  endtask

  task automatic settle_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t index, logic [7:0] value);
    settle_outputs();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    reg_shadow[index] = value;
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(logic [7:0] prescale, logic [7:0] lead_mark,
                              logic [7:0] lead_space, logic [7:0] zero_mark,
                              logic [7:0] zero_space, logic [7:0] one_mark,
                              logic [7:0] one_space, logic [7:0] duty);
    logic [7:0] vals [NUM_REGS];
    vals[REG_PRESCALE]     = prescale;
    vals[REG_LEAD_MARK]    = lead_mark;
    vals[REG_LEAD_SPACE]   = lead_space;
    vals[REG_ZERO_MARK]    = zero_mark;
    vals[REG_ZERO_SPACE]   = zero_space;
    vals[REG_ONE_MARK]     = one_mark;
    vals[REG_ONE_SPACE]    = one_space;
    vals[REG_CARRIER_DUTY] = duty;
    settle_outputs();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_data  <= vals[REG_IDX_W'(i)];
      @(posedge clk);
      reg_shadow[REG_IDX_W'(i)] = vals[REG_IDX_W'(i)];
    end
    cfg_we <= 1'b0;
  endtask

  // Ticks until the frame has ended; now and then a load, start or no-op lands mid-frame.
  task automatic run_frame(int noise_odds);
    while (ph != PH_IDLE) begin
      if (noise_odds != 0 && $urandom_range(noise_odds - 1, 0) == 0)
        send_item(op_t'($urandom_range(3, 1)), 4'($urandom_range(15, 0)),
                  8'($urandom_range(255, 0)), 5'($urandom_range(31, 0)));
      else
        send_item(OP_TICK, 4'($urandom_range(15, 0)), 8'($urandom_range(255, 0)),
                  5'($urandom_range(31, 0)));
    end
  endtask

  // Every other register keeps its reset value; a prescale of zero keeps the frame short.
  task automatic test_default_frame();
    write_reg(REG_PRESCALE, 8'd0);
    send_item(OP_LOAD, 4'd0, 8'hA5, 5'd0);
    send_item(OP_LOAD, 4'd1, 8'hFF, 5'd0);
    send_item(OP_NONE, 4'd2, 8'h5A, 5'd31);
    // A tick with nothing to send must not start the prescaler.
    send_item(OP_TICK, 4'd0, 8'h00, 5'd0);
    send_item(OP_START, 4'd0, 8'h00, 5'd0);
    send_item(OP_START, 4'd0, 8'h00, 5'd1);
    run_frame(0);
  endtask

  // Fills every store entry, so later frames may use any length.
  task automatic test_full_store();
    program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'hFF);
    for (int i = 0; i < MAX_BYTES; i++)
      send_item(OP_LOAD, IDX_W'(i), 8'($urandom_range(255, 0)), 5'd0);
    // A length above the store size is cut down to the whole store.
    send_item(OP_START, 4'd15, 8'hFF, 5'd31);
    run_frame(6);
  endtask

  // The longest leader mark the register allows.
  task automatic test_timing_extremes();
    program_regs(8'h00, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h80);
    send_item(OP_START, 4'($urandom_range(15, 0)), 8'($urandom_range(255, 0)), 5'd1);
    run_frame(0);
  endtask

  task automatic test_random_traffic();
    logic [4:0] len;
    while (item_count < TOTAL_ITEMS) begin
      // Short timings keep most frames within a few dozen ticks.
      if ($urandom_range(4, 0) == 0)
        program_regs(8'($urandom_range(1, 0)), 8'($urandom_range(2, 0)),
                     8'($urandom_range(2, 0)), 8'($urandom_range(1, 0)),
                     8'($urandom_range(1, 0)), 8'($urandom_range(1, 0)),
                     8'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
      src_gap_max    = ($urandom_range(3, 0) == 0) ? 0 : 7;
      sink_stall_max = ($urandom_range(3, 0) == 0) ? 0 : 7;
      repeat ($urandom_range(3, 0))
        send_item(OP_LOAD, 4'($urandom_range(15, 0)), 8'($urandom_range(255, 0)),
                  5'($urandom_range(31, 0)));
      case ($urandom_range(5, 0))
        0: send_item(OP_NONE, 4'($urandom_range(15, 0)), 8'($urandom_range(255, 0)),
                     5'($urandom_range(31, 0)));
        1: send_item(OP_TICK, 4'($urandom_range(15, 0)), 8'($urandom_range(255, 0)),
                     5'($urandom_range(31, 0)));
        2: send_item(OP_START, 4'($urandom_range(15, 0)), 8'($urandom_range(255, 0)), 5'd0);
        default: ;
      endcase
      len = 5'($urandom_range(2, 1));
      send_item(OP_START, 4'($urandom_range(15, 0)), 8'($urandom_range(255, 0)), len);
      run_frame(10);
    end
  endtask

  // Output side: random stalls after each transfer, and comparison with the oldest prediction.
  always @(posedge clk) begin : output_check
    tx_output_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, actual tdata %h tlast %b",
                   $time, m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (m_axis_tdata[7:0] !== want.pwm_compare) begin
            $display("%0t: pwm_compare expected %0d actual %0d",
                     $time, want.pwm_compare, m_axis_tdata[7:0]);
            error_count++;
          end
          if (m_axis_tdata[OUT_BUSY_BIT] !== want.busy) begin
            $display("%0t: busy_res expected %b actual %b",
                     $time, want.busy, m_axis_tdata[OUT_BUSY_BIT]);
            error_count++;
          end
          if (m_axis_tlast !== want.frame_done) begin
            $display("%0t: frame_done expected %b actual %b",
                     $time, want.frame_done, m_axis_tlast);
            error_count++;
          end
        end
        stall_left = $urandom_range(sink_stall_max, 0);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    reg_shadow[REG_PRESCALE]     = PRESCALE_RST;
    reg_shadow[REG_LEAD_MARK]    = LEAD_MARK_RST;
    reg_shadow[REG_LEAD_SPACE]   = LEAD_SPACE_RST;
    reg_shadow[REG_ZERO_MARK]    = ZERO_MARK_RST;
    reg_shadow[REG_ZERO_SPACE]   = ZERO_SPACE_RST;
    reg_shadow[REG_ONE_MARK]     = ONE_MARK_RST;
    reg_shadow[REG_ONE_SPACE]    = ONE_SPACE_RST;
    reg_shadow[REG_CARRIER_DUTY] = CARRIER_DUTY_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_frame();
    test_full_store();
    test_timing_extremes();
    test_random_traffic();
    settle_outputs();
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
